// ----- rtl/core/rv32im_integer_execute_assert.svh -----
// Assertion macros for the RV32IM execute unit checker.
`ifndef RV32IM_INTEGER_EXECUTE_ASSERT_SVH
`define RV32IM_INTEGER_EXECUTE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define RVX_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RVX_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/rvx_pkg.sv -----
// Shared types and constants for the RV32IM execute unit.
package rvx_pkg;
  localparam logic [6:0] OP_REG = 7'h33;
  localparam logic [6:0] OP_IMM = 7'h13;
  localparam logic [6:0] OP_LUI = 7'h37;
  localparam logic [6:0] OP_AUIPC = 7'h17;
  localparam logic [6:0] OP_JAL = 7'h6f;
  localparam logic [6:0] OP_JALR = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT = 7'h20;
  localparam logic [6:0] F7_MUL = 7'h01;

  typedef enum logic [1:0] {
    CLS_ILLEGAL = 2'd0,
    CLS_SIMPLE = 2'd1,
    CLS_MULDIV = 2'd2
  } cls_e;

  typedef struct packed {
    logic [31:0] insn;
    cls_e cls;
  } qent_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [4:0] dest_index;
    logic [31:0] dest_value;
    logic dest_written;
    logic branch_taken;
    logic illegal;
  } res_t;

  localparam int QDEPTH = 2;
endpackage

// ----- rtl/core/rvx_front.sv -----
// Front end: accepts instruction items, classifies them, and queues them.
module rvx_front (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  output logic in_ready_o,
  input logic [31:0] in_insn_i,
  output logic q_valid_o,
  input logic q_pop_i,
  output rvx_pkg::qent_t q_head_o
);
  import rvx_pkg::*;

  qent_t mem_q [QDEPTH];
  logic wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  cls_e cls;
  logic [6:0] op, f7;
  logic [2:0] f3;
  logic push;

  assign op = in_insn_i[6:0];
  assign f3 = in_insn_i[14:12];
  assign f7 = in_insn_i[31:25];

  always_comb begin
    cls = CLS_ILLEGAL;
    case (op)
      OP_REG: begin
        if (f7 == F7_MUL) cls = CLS_MULDIV;
        else if (f7 == F7_BASE) cls = CLS_SIMPLE;
        else if (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)) cls = CLS_SIMPLE;
      end
      OP_IMM: begin
        if (f3 == 3'd1) begin
          if (f7 == F7_BASE) cls = CLS_SIMPLE;
        end else if (f3 == 3'd5) begin
          if (f7 == F7_BASE || f7 == F7_ALT) cls = CLS_SIMPLE;
        end else cls = CLS_SIMPLE;
      end
      OP_LUI, OP_AUIPC, OP_JAL: cls = CLS_SIMPLE;
      OP_JALR: if (f3 == 3'd0) cls = CLS_SIMPLE;
      OP_BRANCH: if (f3 != 3'd2 && f3 != 3'd3) cls = CLS_SIMPLE;
      default: cls = CLS_ILLEGAL;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'(QDEPTH));
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_head_o = mem_q[rp_q];

  always_comb begin
    wp_d = push ? ~wp_q : wp_q;
    rp_d = q_pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{insn: in_insn_i, cls: cls};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

// ----- rtl/core/rvx_muldiv.sv -----
// Multicycle multiply and radix-2 divide unit for the M extension.
module rvx_muldiv (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic [2:0] f3_i,
  input logic [31:0] a_i,
  input logic [31:0] b_i,
  output logic done_o,
  output logic [31:0] res_o
);
  import rvx_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL = 2'd1;
  localparam logic [1:0] S_DIV = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] st_q, st_d;
  logic [2:0] f3_q, f3_d;
  logic [31:0] a_q, a_d, b_q, b_d;
  logic [65:0] prod_q, prod_d;
  logic [31:0] quo_q, quo_d, rem_q, rem_d;
  logic [5:0] cnt_q, cnt_d;
  logic nq_q, nq_d, nr_q, nr_d;
  logic [31:0] res_q, res_d;
  logic sa, sb;
  logic [32:0] xa, xb;
  logic [65:0] mprod;
  logic [32:0] trial;
  logic [31:0] ma, mb;

  always_comb begin
    sa = (f3_i == 3'd1 || f3_i == 3'd2) && a_i[31];
    sb = (f3_i == 3'd1) && b_i[31];
    xa = {sa, a_i};
    xb = {sb, b_i};
    mprod = 66'($signed(xa) * $signed(xb));
    ma = a_i[31] && f3_i[0] == 1'b0 ? (~a_i + 32'd1) : a_i;
    mb = b_i[31] && f3_i[0] == 1'b0 ? (~b_i + 32'd1) : b_i;
    trial = {rem_q, quo_q[31]} - {1'b0, b_q};
  end

  always_comb begin
    st_d = st_q; f3_d = f3_q; a_d = a_q; b_d = b_q; prod_d = prod_q;
    quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q; nq_d = nq_q; nr_d = nr_q;
    res_d = res_q;
    case (st_q)
      S_IDLE: if (start_i) begin
        f3_d = f3_i; a_d = a_i; b_d = b_i;
        if (f3_i[2] == 1'b0) begin
          prod_d = mprod;
          st_d = S_MUL;
        end else begin
          quo_d = ma; rem_d = '0; b_d = mb;
          nq_d = (f3_i[0] == 1'b0) && (a_i[31] ^ b_i[31]);
          nr_d = (f3_i[0] == 1'b0) && a_i[31];
          cnt_d = 6'd32;
          st_d = S_DIV;
        end
      end
      S_MUL: begin
        res_d = (f3_q == 3'd0) ? prod_q[31:0] : prod_q[63:32];
        st_d = S_DONE;
      end
      S_DIV: begin
        if (cnt_q == 6'd0) begin
          if (b_q == 32'd0) res_d = f3_q[1] ? a_q : 32'hffffffff;
          else if (f3_q[1]) res_d = nr_q ? (~rem_q + 32'd1) : rem_q;
          else res_d = nq_q ? (~quo_q + 32'd1) : quo_q;
          st_d = S_DONE;
        end else begin
          if (!trial[32]) begin
            rem_d = trial[31:0];
            quo_d = {quo_q[30:0], 1'b1};
          end else begin
            rem_d = {rem_q[30:0], quo_q[31]};
            quo_d = {quo_q[30:0], 1'b0};
          end
          cnt_d = cnt_q - 6'd1;
        end
      end
      S_DONE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  assign done_o = (st_q == S_DONE);
  assign res_o = res_q;

  always_ff @(posedge clk_i) begin
    f3_q <= f3_d; a_q <= a_d; b_q <= b_d; prod_q <= prod_d;
    quo_q <= quo_d; rem_q <= rem_d; nq_q <= nq_d; nr_q <= nr_d; res_q <= res_d;
    cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= S_IDLE;
    else st_q <= st_d;
  end
endmodule

// ----- rtl/core/rvx_back.sv -----
// Back end: register file, program counter, ALU, branch unit, result register.
module rvx_back (
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_we_i,
  input logic [31:0] cfg_data_i,
  input logic q_valid_i,
  output logic q_pop_o,
  input rvx_pkg::qent_t q_head_i,
  output logic out_valid_o,
  input logic out_ready_i,
  output rvx_pkg::res_t out_res_o
);
  import rvx_pkg::*;

  localparam logic [1:0] S_READ = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MD = 2'd2;

  logic [1:0] st_q, st_d;
  logic [31:0] rf_q [32];
  logic [31:0] a_q, b_q, pc_q;
  logic [31:0] insn;
  logic [6:0] op;
  logic [2:0] f3;
  logic [4:0] rd;
  logic alt;
  logic [31:0] immi, immb, immj, opb, alu, val, npc, sum;
  logic [4:0] sh;
  logic cond, wr, taken, ill;
  logic md_start, md_done;
  logic [31:0] md_res;
  logic fin;
  res_t res_q;
  logic ov_q;

  assign insn = q_head_i.insn;
  assign op = insn[6:0];
  assign f3 = insn[14:12];
  assign rd = insn[11:7];
  assign immi = {{20{insn[31]}}, insn[31:20]};
  assign immb = {{20{insn[31]}}, insn[7], insn[30:25], insn[11:8], 1'b0};
  assign immj = {{12{insn[31]}}, insn[19:12], insn[20], insn[30:21], 1'b0};
  assign opb = (op == OP_REG) ? b_q : immi;
  assign alt = insn[30] && (op == OP_REG || f3 == 3'd5);
  assign sh = opb[4:0];
  assign sum = alt ? a_q - opb : a_q + opb;

  always_comb begin
    case (f3)
      3'd0: alu = sum;
      3'd1: alu = a_q << sh;
      3'd2: alu = {31'd0, $signed(a_q) < $signed(opb)};
      3'd3: alu = {31'd0, a_q < opb};
      3'd4: alu = a_q ^ opb;
      3'd5: alu = alt ? 32'($signed(a_q) >>> sh) : a_q >> sh;
      3'd6: alu = a_q | opb;
      default: alu = a_q & opb;
    endcase
    case (f3)
      3'd0: cond = a_q == b_q;
      3'd1: cond = a_q != b_q;
      3'd4: cond = $signed(a_q) < $signed(b_q);
      3'd5: cond = $signed(a_q) >= $signed(b_q);
      3'd6: cond = a_q < b_q;
      default: cond = a_q >= b_q;
    endcase
    ill = (q_head_i.cls == CLS_ILLEGAL);
    npc = pc_q + 32'd4; val = alu; wr = 1'b1; taken = 1'b0;
    case (op)
      OP_LUI: val = {insn[31:12], 12'd0};
      OP_AUIPC: val = pc_q + {insn[31:12], 12'd0};
      OP_JAL: begin val = pc_q + 32'd4; taken = 1'b1; npc = pc_q + immj; end
      OP_JALR: begin
        val = pc_q + 32'd4; taken = 1'b1;
        npc = (a_q + immi) & ~32'd1;
      end
      OP_BRANCH: begin
        wr = 1'b0;
        if (cond) begin taken = 1'b1; npc = pc_q + immb; end
      end
      default: if (q_head_i.cls == CLS_MULDIV) val = md_res;
    endcase
    if (ill) begin
      npc = pc_q; wr = 1'b0; taken = 1'b0;
    end
    if (rd == 5'd0) wr = 1'b0;
  end

  assign md_start = (st_q == S_READ) && q_valid_i && !ov_q && q_head_i.cls == CLS_MULDIV;

  rvx_muldiv u_md (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(md_start), .f3_i(f3),
    .a_i(rf_q[insn[19:15]]), .b_i(rf_q[insn[24:20]]), .done_o(md_done), .res_o(md_res)
  );

  assign fin = (st_q == S_EXEC) || (st_q == S_MD && md_done);
  assign q_pop_o = fin;
  assign out_valid_o = ov_q;
  assign out_res_o = res_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_READ: if (q_valid_i && !ov_q) st_d = md_start ? S_MD : S_EXEC;
      S_EXEC: st_d = S_READ;
      S_MD: if (md_done) st_d = S_READ;
      default: st_d = S_READ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_READ) begin
      a_q <= rf_q[insn[19:15]];
      b_q <= rf_q[insn[24:20]];
    end
    if (fin) begin
      res_q.next_pc <= npc;
      res_q.dest_index <= wr ? rd : 5'd0;
      res_q.dest_value <= wr ? val : 32'd0;
      res_q.dest_written <= wr;
      res_q.branch_taken <= taken;
      res_q.illegal <= ill;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_READ;
      ov_q <= 1'b0;
      pc_q <= '0;
      for (int i = 0; i < 32; i++) rf_q[i] <= '0;
    end else begin
      st_q <= st_d;
      if (fin) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (cfg_we_i) pc_q <= cfg_data_i;
      else if (fin) pc_q <= npc;
      if (fin && wr) rf_q[rd] <= val;
    end
  end
endmodule

// ----- rtl/core/rv32im_integer_execute.sv -----
// Top level of the RV32IM integer execute unit.
// Executes one RV32IM instruction item at a time against a 32-entry register
// file (x0 reads zero) and a program counter loaded from the start address
// register. A front end accepts and classifies items into a two-entry queue;
// a back end reads operands, executes and writes one result item per input.
// Simple ops pass through the back end's read and execute states; multiplies
// take one registered multiplier pass; divide and remainder run on the
// one-bit-per-cycle restoring divider. Illegal encodings (loads, stores, system,
// bad fields) leave state unchanged and report illegal with the current pc.
// Writing the start address also loads the program counter.
module rv32im_integer_execute (
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_valid_i,
  output logic cfg_ready_o,
  input logic [31:0] cfg_data_i,
  input logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  input logic [31:0] s_axis_tdata_i, // [31:0] instruction_word
  output logic m_axis_tvalid_o,
  input logic m_axis_tready_i,
  // [31:0] next_pc, [36:32] dest_index, [68:37] dest_value,
  // [69] dest_written, [70] branch_taken, [71] illegal
  output logic [71:0] m_axis_tdata_o
);
  import rvx_pkg::*;

  logic q_valid, q_pop;
  qent_t q_head;
  res_t res;

  // Always take configuration; the user must make it arrive only while idle, as nothing here enforces it.
  assign cfg_ready_o = 1'b1;

  rvx_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o), .in_insn_i(s_axis_tdata_i),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_head_o(q_head)
  );

  rvx_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_valid_i), .cfg_data_i(cfg_data_i),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_head_i(q_head),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i), .out_res_o(res)
  );

  assign m_axis_tdata_o = {res.illegal, res.branch_taken, res.dest_written,
                           res.dest_value, res.dest_index, res.next_pc};
endmodule

// ----- rtl/core/rvx_checker.sv -----
// Port-level checker for the execute unit, bound to the top level.
`include "rv32im_integer_execute_assert.svh"
module rvx_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic m_axis_tvalid_i,
  input logic m_axis_tready_i,
  input logic [71:0] m_axis_tdata_i
);
  `RVX_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i))
  `RVX_ASSERT_IMP(a_ill_nowr, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tdata_i[71], !m_axis_tdata_i[69] && !m_axis_tdata_i[70])
  `RVX_ASSERT_IMP(a_x0, clk_i, rst_ni, m_axis_tvalid_i && !m_axis_tdata_i[69], m_axis_tdata_i[68:32] == 37'd0)
  `RVX_ASSERT_IMP(a_wr_idx, clk_i, rst_ni, m_axis_tvalid_i && m_axis_tdata_i[69], m_axis_tdata_i[36:32] != 5'd0)
endmodule

bind rv32im_integer_execute rvx_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .m_axis_tvalid_i(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i), .m_axis_tdata_i(m_axis_tdata_o)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the RV32IM integer execute unit.
`timescale 1ns / 100ps

module tb_top;
  import rvx_pkg::*;

  // Branch funct3 codes, named for readability.
  localparam logic [2:0] BR_EQ = 3'd0;
  localparam logic [2:0] BR_NE = 3'd1;
  localparam logic [2:0] BR_LT = 3'd4;
  localparam logic [2:0] BR_GE = 3'd5;
  localparam logic [2:0] BR_LTU = 3'd6;
  localparam logic [2:0] BR_GEU = 3'd7;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic s_axis_tvalid_i;
  logic s_axis_tready_o;
  logic [31:0] s_axis_tdata_i; // [31:0] instruction_word
  logic m_axis_tvalid_o;
  logic m_axis_tready_i;
  // [31:0] next_pc, [36:32] dest_index, [68:37] dest_value,
  // [69] dest_written, [70] branch_taken, [71] illegal
  logic [71:0] m_axis_tdata_o;

  rv32im_integer_execute u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  // Architectural shadow state of the predictor.
  logic [31:0] arch_regs [32];
  logic [31:0] arch_pc;

  logic [31:0] insn_queue [$];   // pending instruction items for the driver
  res_t retire_queue [$];        // expected results, oldest first
  int unsigned mismatches;
  int unsigned sent_count;
  int unsigned gap_left;
  int unsigned stall_left;
  bit stream_on;                 // driver may present items

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(400_000_000);
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic logic [31:0] read_reg(input logic [4:0] idx);
    return (idx == 5'd0) ? 32'd0 : arch_regs[idx];
  endfunction

  function automatic logic [31:0] sx12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  // Multiply, multiply-high, divide and remainder selected by funct3.
  function automatic logic [31:0] muldiv_value(input logic [2:0] f3, input logic [31:0] a,
                                               input logic [31:0] b);
    logic signed [63:0] ps;
    logic [63:0] pu;
    logic signed [65:0] psu;
    case (f3)
      3'd0: return a * b;
      3'd1: begin
        ps = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        return ps[63:32];
      end
      3'd2: begin
        psu = $signed({{34{a[31]}}, a}) * $signed({34'd0, b});
        return psu[63:32];
      end
      3'd3: begin
        pu = {32'd0, a} * {32'd0, b};
        return pu[63:32];
      end
      3'd4: begin
        if (b == 0) return 32'hffff_ffff;
        if (a == 32'h8000_0000 && b == 32'hffff_ffff) return 32'h8000_0000;
        return $signed(a) / $signed(b);
      end
      3'd5: return (b == 0) ? 32'hffff_ffff : a / b;
      3'd6: begin
        if (b == 0) return a;
        if (a == 32'h8000_0000 && b == 32'hffff_ffff) return 32'd0;
        return $signed(a) % $signed(b);
      end
      default: return (b == 0) ? a : a % b;
    endcase
  endfunction

  // Execute one instruction against the shadow state and return its result.
  function automatic res_t execute_insn(input logic [31:0] w);
    res_t r;
    logic [6:0] op, f7;
    logic [4:0] rd;
    logic [2:0] f3;
    logic [31:0] a, b, val, npc, boff;
    logic ok, wr, taken;
    op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
    a = read_reg(w[19:15]); b = read_reg(w[24:20]);
    npc = arch_pc + 4; val = 0; ok = 1; wr = 0; taken = 0;
    case (op)
      OP_REG: begin
        wr = 1;
        if (f7 == F7_MUL) val = muldiv_value(f3, a, b);
        else if (f7 == F7_ALT && f3 == 3'd0) val = a - b;
        else if (f7 == F7_ALT && f3 == 3'd5) val = $signed(a) >>> b[4:0];
        else if (f7 != F7_BASE) ok = 0;
        else case (f3)
          3'd0: val = a + b;
          3'd1: val = a << b[4:0];
          3'd2: val = {31'd0, $signed(a) < $signed(b)};
          3'd3: val = {31'd0, a < b};
          3'd4: val = a ^ b;
          3'd5: val = a >> b[4:0];
          3'd6: val = a | b;
          default: val = a & b;
        endcase
      end
      OP_IMM: begin
        wr = 1;
        case (f3)
          3'd0: val = a + sx12(w[31:20]);
          3'd1: if (f7 != F7_BASE) ok = 0; else val = a << w[24:20];
          3'd2: val = {31'd0, $signed(a) < $signed(sx12(w[31:20]))};
          3'd3: val = {31'd0, a < sx12(w[31:20])};
          3'd4: val = a ^ sx12(w[31:20]);
          3'd5: begin
            if (f7 == F7_BASE) val = a >> w[24:20];
            else if (f7 == F7_ALT) val = $signed(a) >>> w[24:20];
            else ok = 0;
          end
          3'd6: val = a | sx12(w[31:20]);
          default: val = a & sx12(w[31:20]);
        endcase
      end
      OP_LUI: begin val = {w[31:12], 12'd0}; wr = 1; end
      OP_AUIPC: begin val = arch_pc + {w[31:12], 12'd0}; wr = 1; end
      OP_JAL: begin
        val = arch_pc + 4; wr = 1; taken = 1;
        npc = arch_pc + {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      OP_JALR: begin
        if (f3 != 3'd0) ok = 0;
        else begin
          val = arch_pc + 4; wr = 1; taken = 1;
          npc = (a + sx12(w[31:20])) & ~32'd1;
        end
      end
      OP_BRANCH: begin
        case (f3)
          BR_EQ: taken = (a == b);
          BR_NE: taken = (a != b);
          BR_LT: taken = $signed(a) < $signed(b);
          BR_GE: taken = !($signed(a) < $signed(b));
          BR_LTU: taken = a < b;
          BR_GEU: taken = a >= b;
          default: ok = 0;
        endcase
        boff = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        if (ok && taken) npc = arch_pc + boff;
        else taken = 0;
      end
      default: ok = 0;
    endcase
    r = '0;
    if (!ok) begin
      r.next_pc = arch_pc;
      r.illegal = 1'b1;
      return r;
    end
    if (wr && rd != 0) arch_regs[rd] = val;
    else begin wr = 0; rd = 0; val = 0; end
    arch_pc = npc;
    r.next_pc = npc; r.dest_index = rd; r.dest_value = val;
    r.dest_written = wr; r.branch_taken = taken;
    return r;
  endfunction

  // Random gap length: mostly zero or short, occasionally long.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Driver: present queued items with random gaps; predict at acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
      gap_left <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        retire_queue.push_back(execute_insn(s_axis_tdata_i));
        sent_count <= sent_count + 1;
      end
      if (s_axis_tvalid_i && !s_axis_tready_o) begin
        // hold the item until accepted
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (stream_on && insn_queue.size() != 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= insn_queue.pop_front();
        gap_left <= pick_gap();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Monitor: random backpressure, compare accepted results in order.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        // Unpack the result item from the lowest field up.
        got.next_pc = m_axis_tdata_o[31:0];
        got.dest_index = m_axis_tdata_o[36:32];
        got.dest_value = m_axis_tdata_o[68:37];
        got.dest_written = m_axis_tdata_o[69];
        got.branch_taken = m_axis_tdata_o[70];
        got.illegal = m_axis_tdata_o[71];
        if (retire_queue.size() == 0) begin
          report_mismatch("unexpected result", got.next_pc, 32'd0);
        end else begin
          want = retire_queue.pop_front();
          if (got.next_pc !== want.next_pc)
            report_mismatch("next_pc", got.next_pc, want.next_pc);
          if (got.dest_index !== want.dest_index)
            report_mismatch("dest_index", got.dest_index, want.dest_index);
          if (got.dest_value !== want.dest_value)
            report_mismatch("dest_value", got.dest_value, want.dest_value);
          if (got.dest_written !== want.dest_written)
            report_mismatch("dest_written", got.dest_written, want.dest_written);
          if (got.branch_taken !== want.branch_taken)
            report_mismatch("branch_taken", got.branch_taken, want.branch_taken);
          if (got.illegal !== want.illegal)
            report_mismatch("illegal", got.illegal, want.illegal);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  // Encoders for well-formed instructions.
  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_b(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [12:0] off);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OP_BRANCH};
  endfunction

  // Random register index, biased toward a small pool so values get reused.
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
  endfunction

  // Operand-rich random value: corners or random bits.
  function automatic logic [11:0] pick_imm();
    case ($urandom_range(4))
      0: return 12'h7ff;
      1: return 12'h800;
      2: return 12'hfff;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_insn();
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    int unsigned k;
    rd = pick_reg(); rs1 = pick_reg(); rs2 = pick_reg();
    f3 = 3'($urandom);
    k = $urandom_range(99);
    if (k < 22) return enc_r(F7_BASE, f3, rd, rs1, rs2);
    if (k < 28) return enc_r(F7_ALT, ($urandom_range(1) != 0) ? 3'd0 : 3'd5, rd, rs1, rs2);
    if (k < 42) return enc_r(F7_MUL, f3, rd, rs1, rs2);
    if (k < 60) begin
      if (f3 == 3'd1) return enc_i(OP_IMM, f3, rd, rs1, {7'd0, rs2});
      if (f3 == 3'd5)
        return enc_i(OP_IMM, f3, rd, rs1, {($urandom_range(1) != 0) ? F7_ALT : F7_BASE, rs2});
      return enc_i(OP_IMM, f3, rd, rs1, pick_imm());
    end
    if (k < 66) return {20'($urandom), rd, OP_LUI};
    if (k < 70) return {20'($urandom), rd, OP_AUIPC};
    if (k < 74) return {20'($urandom), rd, OP_JAL};
    if (k < 78) return enc_i(OP_JALR, 3'd0, rd, rs1, pick_imm());
    if (k < 90) return enc_b(f3, rs1, rs2, 13'($urandom));
    return $urandom;  // noise: mostly illegal encodings
  endfunction

  task automatic wait_idle();
    while (insn_queue.size() != 0 || s_axis_tvalid_i || retire_queue.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the start address while the unit is idle; the pc follows it.
  task automatic write_start(input logic [31:0] addr);
    cfg_data_i <= addr;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    arch_pc = addr;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    mismatches = 0;
    sent_count = 0;
    stream_on = 1'b0;
    arch_pc = '0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme operands, every operation class, special cases.
    write_start(32'hffff_fffc);
    insn_queue.push_back({20'h80000, 5'd1, OP_LUI});               // x1 = INT_MIN
    insn_queue.push_back(enc_i(OP_IMM, 3'd0, 5'd2, 5'd0, 12'hfff)); // x2 = -1
    insn_queue.push_back(enc_r(F7_MUL, 3'd4, 5'd3, 5'd1, 5'd2));   // overflow divide
    insn_queue.push_back(enc_r(F7_MUL, 3'd6, 5'd4, 5'd1, 5'd2));   // overflow remainder
    insn_queue.push_back(enc_r(F7_MUL, 3'd4, 5'd5, 5'd1, 5'd0));   // divide by zero
    insn_queue.push_back(enc_r(F7_MUL, 3'd5, 5'd6, 5'd2, 5'd0));
    insn_queue.push_back(enc_r(F7_MUL, 3'd6, 5'd7, 5'd1, 5'd0));
    insn_queue.push_back(enc_r(F7_MUL, 3'd7, 5'd8, 5'd2, 5'd0));
    insn_queue.push_back(enc_r(F7_MUL, 3'd1, 5'd9, 5'd1, 5'd1));   // high products
    insn_queue.push_back(enc_r(F7_MUL, 3'd2, 5'd10, 5'd2, 5'd2));
    insn_queue.push_back(enc_r(F7_MUL, 3'd3, 5'd11, 5'd2, 5'd2));
    insn_queue.push_back(enc_r(F7_BASE, 3'd0, 5'd0, 5'd2, 5'd2));  // write to x0 dropped
    insn_queue.push_back(enc_i(OP_IMM, 3'd5, 5'd12, 5'd1, {F7_ALT, 5'd31}));
    insn_queue.push_back(enc_i(OP_IMM, 3'd1, 5'd13, 5'd1, {7'h10, 5'd1})); // bad shift
    insn_queue.push_back(enc_b(BR_GE, 5'd2, 5'd1, 13'h1ffc));      // signed compare
    insn_queue.push_back(enc_b(BR_LTU, 5'd1, 5'd2, 13'h0ffe));
    insn_queue.push_back(enc_b(3'd2, 5'd1, 5'd2, 13'h0010));       // bad branch funct3
    insn_queue.push_back({20'hfffff, 5'd14, OP_AUIPC});
    insn_queue.push_back({1'b1, 10'h3ff, 1'b1, 8'hff, 5'd15, OP_JAL});
    insn_queue.push_back(enc_i(OP_JALR, 3'd0, 5'd16, 5'd2, 12'h7ff)); // even target sum
    insn_queue.push_back(enc_i(OP_JALR, 3'd1, 5'd16, 5'd2, 12'h000)); // bad funct3
    insn_queue.push_back(32'h0000_2003);                             // load
    insn_queue.push_back(32'h0000_0073);                             // ecall
    insn_queue.push_back(32'hffff_ffff);
    insn_queue.push_back(32'h0000_0000);
    stream_on = 1'b1;
    wait_idle();

    // Random phases across several start addresses.
    for (int phase = 0; phase < 4; phase++) begin
      stream_on = 1'b0;
      case (phase)
        0: write_start(32'h0000_0000);
        1: write_start(32'h7fff_fff0);
        2: write_start($urandom);
        default: write_start(32'hffff_ffff);
      endcase
      for (int n = 0; n < 470; n++) insn_queue.push_back(random_insn());
      stream_on = 1'b1;
      // Hold the sender mid-phase until every result is back.
      while (insn_queue.size() > 235) @(posedge clk_i);
      stream_on = 1'b0;
      while (s_axis_tvalid_i || retire_queue.size() != 0) @(posedge clk_i);
      stream_on = 1'b1;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- rv32im_integer_execute.f -----
+incdir+rtl/core
rtl/core/rvx_pkg.sv
rtl/core/rvx_front.sv
rtl/core/rvx_muldiv.sv
rtl/core/rvx_back.sv
rtl/core/rv32im_integer_execute.sv
rtl/core/rvx_checker.sv
tb/tb_top.sv
